@@ src/ealu_pkg.sv @@
package ealu_pkg;

  localparam int W     = 32;
  localparam int CNT_W = $clog2(W);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(W - 1);

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_AND = 3'd4,
    OP_OR  = 3'd5,
    OP_NOT = 3'd6,
    OP_NOP = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_HOLD
  } state_t;

  // Sequencer to datapath units
  typedef struct packed {
    logic load;
    logic step;
  } ctl_t;

  typedef struct packed {
    logic [W-1:0] low;
    logic [W-1:0] high;
    logic         carry;
    logic         minus;
  } bits_res_t;

  typedef struct packed {
    logic [W-1:0] low;
    logic [W-1:0] high;
    logic         b_zero;
  } md_res_t;

endpackage

@@ src/ealu_bits.sv @@
module ealu_bits (
  input  logic               clk,
  input  ealu_pkg::ctl_t     ctl,
  input  ealu_pkg::op_t      op,
  input  logic [31:0]        operand_a,
  input  logic [31:0]        operand_b,
  output ealu_pkg::bits_res_t res
);
  import ealu_pkg::*;

  op_t          op_r;
  logic [W-1:0] a_sr_r, b_sr_r, prim_sr_r, dba_sr_r;
  logic         c_r, br_ab_r, br_ba_r, nz_r;
  logic         ai, bi, sum_bit, d_ab, d_ba, prim;

  assign ai      = a_sr_r[0];
  assign bi      = b_sr_r[0];
  assign sum_bit = ai ^ bi ^ c_r;
  assign d_ab    = ai ^ bi ^ br_ab_r;
  assign d_ba    = ai ^ bi ^ br_ba_r;

  always_comb begin
    case (op_r)
      OP_ADD:  prim = sum_bit;
      OP_SUB:  prim = d_ab;
      OP_AND:  prim = ai & bi;
      OP_OR:   prim = ai | bi;
      default: prim = 1'b0;
    endcase
  end

  // LSB first: operands shift out, result bits enter from the top
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      op_r    <= op;
      a_sr_r  <= operand_a;
      b_sr_r  <= operand_b;
      c_r     <= 1'b0;
      br_ab_r <= 1'b0;
      br_ba_r <= 1'b0;
      nz_r    <= 1'b0;
    end else if (ctl.step) begin
      a_sr_r    <= {1'b0, a_sr_r[W-1:1]};
      b_sr_r    <= {1'b0, b_sr_r[W-1:1]};
      prim_sr_r <= {prim, prim_sr_r[W-1:1]};
      dba_sr_r  <= {d_ba, dba_sr_r[W-1:1]};
      c_r       <= (ai & bi) | (c_r & (ai ^ bi));
      br_ab_r   <= (~ai & bi) | (br_ab_r & ~(ai ^ bi));
      br_ba_r   <= (ai & ~bi) | (br_ba_r & ~(ai ^ bi));
      nz_r      <= nz_r | ai;
    end
  end

  always_comb begin
    case (op_r)
      OP_SUB:  res.low = br_ab_r ? dba_sr_r : prim_sr_r;
      OP_NOT:  res.low = {{(W-1){1'b0}}, ~nz_r};
      default: res.low = prim_sr_r;
    endcase
    res.high  = {{(W-1){1'b0}}, (op_r == OP_ADD) & c_r};
    res.carry = c_r;
    res.minus = br_ab_r;
  end

endmodule

@@ src/ealu_muldiv.sv @@
module ealu_muldiv (
  input  logic             clk,
  input  ealu_pkg::ctl_t   ctl,
  input  ealu_pkg::op_t    op,
  input  logic [31:0]      operand_a,
  input  logic [31:0]      operand_b,
  output ealu_pkg::md_res_t res
);
  import ealu_pkg::*;

  logic         is_div_r;
  logic [W-1:0] hi_r, lo_r, b_r;
  logic [W:0]   add_sum;
  logic [W:0]   trial;
  logic [W+1:0] trial_diff;
  logic         q_bit;

  // Multiply: shift-add, one multiplier bit a step
  assign add_sum = {1'b0, hi_r} + (lo_r[0] ? {1'b0, b_r} : {(W+1){1'b0}});

  // Divide: restoring, one quotient bit a step; a zero divisor gives all ones, remainder a
  assign trial      = {hi_r, lo_r[W-1]};
  assign trial_diff = {1'b0, trial} - {2'b00, b_r};
  assign q_bit      = ~trial_diff[W+1];

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      is_div_r <= (op == OP_DIV);
      hi_r     <= '0;
      lo_r     <= operand_a;
      b_r      <= operand_b;
    end else if (ctl.step) begin
      if (is_div_r) begin
        hi_r <= q_bit ? trial_diff[W-1:0] : trial[W-1:0];
        lo_r <= {lo_r[W-2:0], q_bit};
      end else begin
        hi_r <= add_sum[W:1];
        lo_r <= {add_sum[0], lo_r[W-1:1]};
      end
    end
  end

  assign res.low    = lo_r;
  assign res.high   = hi_r;
  assign res.b_zero = (b_r == '0);

endmodule

@@ src/emulated_alu_with_sticky_flags.sv @@
// Emulated-machine 32-bit ALU (add, sub, mul, div, and, or, logical not) with sticky
// carry, minus and overflow flags. Every operation runs through a radix-2 serial
// datapath: add, sub and the logic ops one bit per cycle, multiply as shift-add and
// divide as restoring division, one step per cycle. The operands load at the edge that
// accepts the beat; 32 steps follow, set by the operand width, then the output register
// captures the result; out_valid and in_ready then rise together. A result left
// waiting on the output stalls the finished operation until out_ready takes it. One
// item is in flight at a time; in_ready is high whenever the datapath is free, even
// while a previous result waits on the output. The flags on each result are those
// after its operation. A zero divisor yields an all-ones quotient, remainder operand_a
// and divide_by_zero set.
module emulated_alu_with_sticky_flags (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_op,
  input  logic [31:0] in_operand_a,
  input  logic [31:0] in_operand_b,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_result_low,
  output logic [31:0] out_result_high,
  output logic        out_carry_flag,
  output logic        out_minus_flag,
  output logic        out_overflow_flag,
  output logic        out_divide_by_zero
);
  import ealu_pkg::*;

  state_t          state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  op_t             op_r;
  ctl_t            ctl;
  bits_res_t       bits_res;
  md_res_t         md_res;
  logic            in_beat, out_load;

  logic            carry_r, carry_nxt;
  logic            minus_r, minus_nxt;
  logic            ovf_r, ovf_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [W-1:0]    low_r, low_nxt, high_r, high_nxt;
  logic            carry_out_r, minus_out_r, ovf_out_r, dz_r, dz_nxt;

  ealu_bits u_bits (
    .clk       (clk),
    .ctl       (ctl),
    .op        (op_t'(in_op)),
    .operand_a (in_operand_a),
    .operand_b (in_operand_b),
    .res       (bits_res)
  );

  ealu_muldiv u_muldiv (
    .clk       (clk),
    .ctl       (ctl),
    .op        (op_t'(in_op)),
    .operand_a (in_operand_a),
    .operand_b (in_operand_b),
    .res       (md_res)
  );

  assign in_ready = (state_r == ST_IDLE);
  assign in_beat  = in_valid & in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    ctl.load  = 1'b0;
    ctl.step  = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_beat) begin
          ctl.load  = 1'b1;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        ctl.step = 1'b1;
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == LAST_STEP) begin
          state_nxt = ST_HOLD;
        end
      end
      ST_HOLD: begin
        // hold the unit results until the output register is free
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      op_r <= op_t'(in_op);
    end
  end

  always_comb begin
    carry_nxt = carry_r;
    minus_nxt = minus_r;
    ovf_nxt   = ovf_r;
    dz_nxt    = 1'b0;
    low_nxt   = bits_res.low;
    high_nxt  = bits_res.high;
    case (op_r)
      OP_ADD: carry_nxt = bits_res.carry;
      OP_SUB: minus_nxt = bits_res.minus;
      OP_MUL: begin
        ovf_nxt  = (md_res.high != '0);
        low_nxt  = md_res.low;
        high_nxt = md_res.high;
      end
      OP_DIV: begin
        ovf_nxt  = 1'b0;
        dz_nxt   = md_res.b_zero;
        low_nxt  = md_res.low;
        high_nxt = md_res.high;
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      carry_r     <= 1'b0;
      minus_r     <= 1'b0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (out_load) begin
        carry_r <= carry_nxt;
        minus_r <= minus_nxt;
        ovf_r   <= ovf_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      low_r       <= low_nxt;
      high_r      <= high_nxt;
      carry_out_r <= carry_nxt;
      minus_out_r <= minus_nxt;
      ovf_out_r   <= ovf_nxt;
      dz_r        <= dz_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_result_low     = low_r;
  assign out_result_high    = high_r;
  assign out_carry_flag     = carry_out_r;
  assign out_minus_flag     = minus_out_r;
  assign out_overflow_flag  = ovf_out_r;
  assign out_divide_by_zero = dz_r;

  a_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (cnt_r == '0))
    else $error("step counter not at zero while idle");

  a_beat_runs: assert property (@(posedge clk) disable iff (!rst_n)
    in_beat |=> (state_r == ST_RUN))
    else $error("accepted beat did not start the datapath");

  a_out_from_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !$past(out_valid_r)) |-> $past(state_r == ST_HOLD))
    else $error("result raised without a finished operation");

  a_dz_clears_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && dz_r) |-> !ovf_out_r)
    else $error("overflow set on a divide result");

endmodule
